>>> rtl/dbe_pkg.sv
// ----------------------------------------------------------------------------
// dbe_pkg
// Shared widths, codes and types for the multi-channel debouncer.
// ----------------------------------------------------------------------------
package dbe_pkg;

    localparam int PIN_W   = 6;
    localparam int LEVEL_W = 6;
    localparam int EVENT_W = 4;
    localparam int COUNT_W = 8;

    localparam logic [EVENT_W-1:0] EV_NONE       = 4'd0;
    localparam logic [COUNT_W-1:0] SAMPLES_RESET = 8'd3;

    typedef logic [EVENT_W-1:0] event_code_t;
    typedef logic [COUNT_W-1:0] count_t;

    // per-tick status handed out by each cell
    typedef struct packed {
        logic        level;  // debounced level after this tick
        logic        took;   // level changed on this tick
        event_code_t code;   // winning event so far along the row
    } dbe_cell_out_t;

endpackage

>>> rtl/dbe_cell.sv
// ----------------------------------------------------------------------------
// dbe_cell
// One debounce channel: held level, run counter and event hand-on.
// ----------------------------------------------------------------------------
module dbe_cell
    import dbe_pkg::*;
#(
    parameter logic [EVENT_W-1:0] ON_CODE  = 4'd1,
    parameter logic [EVENT_W-1:0] OFF_CODE = 4'd7
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          advance,
    input  logic          raw_active,
    input  count_t        sample_count,
    input  event_code_t   code_in,
    output dbe_cell_out_t cell_out
);

    logic   level_reg, level_next;
    count_t count_reg, count_next;
    count_t count_inc;
    logic   differ;
    logic   take;

    assign differ    = raw_active != level_reg;
    assign count_inc = count_reg + count_t'(1);
    assign take      = differ && (count_inc == sample_count);

    always_comb begin
        level_next = take ? raw_active : level_reg;
        count_next = (differ && !take) ? count_inc : '0;
    end

    always_comb begin
        cell_out.level = level_next;
        cell_out.took  = take;
        cell_out.code  = take ? (raw_active ? ON_CODE : OFF_CODE) : code_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= 1'b0;
            count_reg <= '0;
        end else if (advance) begin
            level_reg <= level_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/multi_channel_debounce_edge_events.sv
// ----------------------------------------------------------------------------
// multi_channel_debounce_edge_events
// Row of counter debounce cells on active-low pins, reporting the
// highest-numbered level change of each sample as an on/off event.
//
//   channel  | ports                                   | role
//   ---------+-----------------------------------------+---------------------
//   s_       | s_valid s_ready s_pin_levels            | pin sample in
//   m_       | m_valid m_ready m_event_code            | event and levels out
//            | m_debounced_levels                      |
//   cfg_     | cfg_valid cfg_ready cfg_sample_count    | sample count write
//
// One sample per cycle; each transaction yields one result, registered in
// the output register for the next cycle. The event passes along the cell
// row in the same cycle. Input stalls only while the output register is full
// and not taken. Sync reset clears cell levels and counters, sample count 3.
// ----------------------------------------------------------------------------
module multi_channel_debounce_edge_events
    import dbe_pkg::*;
#(
    parameter int CHANNELS = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [PIN_W-1:0]   s_pin_levels,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [EVENT_W-1:0] m_event_code,
    output logic [LEVEL_W-1:0] m_debounced_levels,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_sample_count
);

    count_t             sample_count_reg;
    logic               out_valid_reg;
    event_code_t        code_reg;
    logic [LEVEL_W-1:0] levels_reg;
    logic [LEVEL_W-1:0] levels_next;
    logic               accept;
    logic [CHANNELS-1:0] raw_active;
    logic [CHANNELS-1:0] level_vec;
    logic [CHANNELS-1:0] took_vec;
    dbe_cell_out_t       cell_out [CHANNELS];
    event_code_t         chain_code [CHANNELS+1];

    assign cfg_ready = 1'b1;
    assign s_ready   = !out_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= SAMPLES_RESET;
        end else if (cfg_valid) begin
            sample_count_reg <= cfg_sample_count;
        end
    end

    assign chain_code[0] = EV_NONE;

    for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
        // pins beyond the port read as active
        if (i < PIN_W) begin : g_pin
            assign raw_active[i] = ~s_pin_levels[i];
        end else begin : g_nopin
            assign raw_active[i] = 1'b1;
        end

        dbe_cell #(
            .ON_CODE  (EVENT_W'(i + 1)),
            .OFF_CODE (EVENT_W'(CHANNELS + i + 1))
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .advance      (accept),
            .raw_active   (raw_active[i]),
            .sample_count (sample_count_reg),
            .code_in      (chain_code[i]),
            .cell_out     (cell_out[i])
        );

        assign chain_code[i+1] = cell_out[i].code;
        assign level_vec[i]    = cell_out[i].level;
        assign took_vec[i]     = cell_out[i].took;
    end

    for (genvar k = 0; k < LEVEL_W; k++) begin : g_lvl
        if (k < CHANNELS) begin : g_ch
            assign levels_next[k] = level_vec[k];
        end else begin : g_none
            assign levels_next[k] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            code_reg   <= chain_code[CHANNELS];
            levels_reg <= levels_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_event_code       = code_reg;
    assign m_debounced_levels = levels_reg;

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("transaction accepted without a result");

    a_no_change_no_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !(|took_vec)) |=> (m_event_code == EV_NONE))
        else $error("event reported without a level change");

    a_levels_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !accept) |=> $stable({m_event_code, m_debounced_levels}))
        else $error("debounced levels moved without a transaction");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output register");

endmodule
